// File: sv/fsq_pkg.sv
// Package for the single-precision square root block: widths, constants, the stage type.
// No dependencies.
package fsq_pkg;
   localparam int MANT_W = 23;
   localparam int EXP_W = 8;
   localparam int RAD_W = 50;             // radicand width (25-bit mantissa << 25)
   localparam int ROOT_W = 25;            // integer root bits
   localparam int STEPS_PER_STAGE = 5;
   localparam int NUM_STAGES = ROOT_W / STEPS_PER_STAGE;
   localparam logic [31:0] PLUS_INF = 32'h7F80_0000;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic                special;     // result fixed, skip root
      logic [31:0]         fixed;
      logic [EXP_W-1:0]    rexp;
      logic [RAD_W-1:0]    rad;         // remaining radicand bits, consumed two at a time
      logic [ROOT_W+1:0]   rem;         // partial remainder
      logic [ROOT_W-1:0]   root;        // partial root
   } stage_type;
endpackage

// File: sv/float_sqrt_clamp_nonpositive_top.sv
// Single-precision square root stream block, top level.
// Depends on fsq_pkg, fsq_prep, fsq_root_stage, fsq_round.
//
// Usage: req_tdata carries a binary32 value, req_tlast marks the last item.
// rsp_tdata returns the correctly rounded square root for values greater
// than zero (subnormals included, +inf gives +inf); zeros, negatives and
// NaNs give plus zero. rsp_tlast copies req_tlast.
// Pipeline: the item passes seven registers (prep, five root stages of five
// bits each, round/output register); the first of them loads at the
// accepting edge, and rsp_tvalid rises when the last one loads.
// Throughput: one item per cycle unless stalled; five root stages set depth.
// Stall: when rsp_tready is low with a valid result, the whole pipeline
// holds; req_tready stays high while the output register is free or taken.
// Reset: synchronous active-high reset clears all valid bits; payload is
// left as is.
module float_sqrt_clamp_nonpositive_top import fsq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value_bits
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] root_bits
   output logic        rsp_tlast
);
   logic      adv;
   stage_type st [NUM_STAGES+1];

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   fsq_prep u_prep (
      .clock, .reset, .adv,
      .in_valid(req_tvalid), .value_bits(req_tdata), .last_in(req_tlast),
      .q(st[0])
   );

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_root
      fsq_root_stage u_stage (.clock, .reset, .adv, .d(st[g]), .q(st[g+1]));
   end

   fsq_round u_round (
      .clock, .reset, .adv, .d(st[NUM_STAGES]),
      .valid(rsp_tvalid), .root_bits(rsp_tdata), .last_out(rsp_tlast)
   );
endmodule

// File: sv/fsq_prep.sv
// Front stage: unpack, normalize subnormals, even exponent, build radicand.
// Depends on fsq_pkg.
module fsq_prep import fsq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [31:0] value_bits,
   input  logic        last_in,
   output stage_type   q
);
   stage_type q_ff, q_in;
   logic [7:0]  expf;
   logic [22:0] frac;
   logic [4:0]  lz;
   logic [23:0] m;
   logic [24:0] m2;
   logic signed [9:0] e;
   logic signed [9:0] unb;

   always_comb begin
      expf = value_bits[30:23];
      frac = value_bits[22:0];
      lz = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (frac[i]) lz = 5'(22 - i);
      end
      if (expf == 8'd0) begin
         m = {1'b0, frac} << (lz + 5'd1);
         e = 10'sd0 - 10'(lz);
      end else begin
         m = {1'b1, frac};
         e = 10'(expf);
      end
      unb = e - 10'sd127;
      if (unb[0]) begin
         m2 = {m, 1'b0};
         unb = unb - 10'sd1;
      end else begin
         m2 = {1'b0, m};
      end
      q_in = '0;
      q_in.valid = in_valid;
      q_in.last = last_in;
      q_in.rexp = 8'((unb >>> 1) + 10'sd127);
      q_in.rad = {m2, 25'd0} >> 2;   // big = m2 << 23, aligned to even width
      q_in.special = 1'b1;
      if (value_bits[31] || value_bits == 32'd0) begin
         q_in.fixed = 32'd0;
      end else if (expf == 8'hFF) begin
         q_in.fixed = (frac != 23'd0) ? 32'd0 : PLUS_INF;
      end else begin
         q_in.special = 1'b0;
         q_in.fixed = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end
   assign q = q_ff;
endmodule

// File: sv/fsq_root_stage.sv
// One pipeline stage of restoring square root, several result bits per stage.
// Depends on fsq_pkg.
module fsq_root_stage import fsq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  stage_type d,
   output stage_type q
);
   stage_type q_ff, q_in;
   logic [ROOT_W+1:0] trial;

   always_comb begin
      q_in = d;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         q_in.rem = {q_in.rem[ROOT_W-1:0], q_in.rad[RAD_W-1 -: 2]};
         q_in.rad = q_in.rad << 2;
         trial = {q_in.root, 2'b01};
         if (q_in.rem >= trial) begin
            q_in.rem = q_in.rem - trial;
            q_in.root = {q_in.root[ROOT_W-2:0], 1'b1};
         end else begin
            q_in.root = {q_in.root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end
   assign q = q_ff;
endmodule

// File: sv/fsq_round.sv
// Final stage: round to nearest, pack result, hold in the output register.
// Depends on fsq_pkg.
module fsq_round import fsq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  stage_type   d,
   output logic        valid,
   output logic [31:0] root_bits,
   output logic        last_out
);
   logic        valid_ff;
   logic [31:0] root_ff, root_in;
   logic        last_ff;
   logic [ROOT_W:0] r;
   logic [7:0]      rexp;

   always_comb begin
      r = {1'b0, d.root};
      rexp = d.rexp;
      if ({{(ROOT_W+1){1'b0}}, d.rem} > {2'b0, r[ROOT_W-1:0]})
         r = r + (ROOT_W+1)'(1);
      if (r[24]) begin
         r = r >> 1;
         rexp = rexp + 8'd1;
      end
      root_in = d.special ? d.fixed : {1'b0, rexp[7:0], r[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= d.valid;
         root_ff <= root_in;
         last_ff <= d.last;
      end
   end
   assign valid = valid_ff;
   assign root_bits = root_ff;
   assign last_out = last_ff;
endmodule
